// ----- rtl/twop_pkg.sv -----
// shared types, constants and helper functions of the three-wheel odometry block
`timescale 1ns / 1ps

package twop_pkg;

    // default iteration count of the cordic rotator
    localparam int CORDIC_STEPS_DEF = 24;

    // serial arithmetic unit widths
    localparam int MUL_W = 34;
    localparam int DIV_N = 61;
    localparam int DIV_D = 31;

    // fixed-point constants
    localparam logic signed [33:0] GAIN_Q30        = 34'sd652032874;
    localparam logic [31:0]        RAD_TO_BAM_Q30  = 32'd2734261102;
    localparam logic [30:0]        TRACK_WIDTH_RST = 31'd655360;
    localparam logic signed [31:0] TURN_EPS        = 32'sd4096;
    localparam logic [30:0]        TURN_MAG_MAX    = 31'h7FFF_FFFF;

    // request beat
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] left_position;
        logic signed [31:0] right_position;
        logic signed [31:0] back_position;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic [31:0]        new_heading;
    } t_req;

    // result beat
    typedef struct packed {
        logic signed [31:0] pose_x_out;
        logic signed [31:0] pose_y_out;
        logic [31:0]        heading_out;
    } t_pose;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    // request kinds
    typedef enum logic {
        REQ_UPDATE,
        REQ_SET
    } t_req_kind;

    // register map
    typedef enum logic {
        REG_TRACK_WIDTH,
        REG_BACK_OFFSET
    } t_reg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DLAUNCH,
        S_MLAUNCH,
        S_MUL,
        S_CINIT,
        S_CORD,
        S_CFIN,
        S_DONE
    } t_state;

    // products in evaluation order
    typedef enum logic [3:0] {
        M_TK,
        M_TB,
        M_AF,
        M_BS,
        M_BF,
        M_AS,
        M_XC,
        M_YS,
        M_XS,
        M_YC
    } t_mop;

    // quotients
    typedef enum logic [1:0] {
        D_T,
        D_A,
        D_B
    } t_dop;

    // cordic angle source
    typedef enum logic {
        C_TURN,
        C_HEAD
    } t_cop;

    // arctangent of 2^-i as a binary angle
    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2F9;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            5'd24: v = 32'h0000_0029;
            5'd25: v = 32'h0000_0014;
            5'd26: v = 32'h0000_000A;
            5'd27: v = 32'h0000_0005;
            5'd28: v = 32'h0000_0003;
            5'd29: v = 32'h0000_0001;
            5'd30: v = 32'h0000_0001;
            5'd31: v = 32'h0000_0000;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        logic signed [31:0] r;
        if (v > 41'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -41'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/twop_if.sv -----
// valid/ready channels for request and result beats
`timescale 1ns / 1ps

interface twop_req_if import twop_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface twop_pose_if import twop_pkg::*; ();
    logic  valid;
    logic  ready;
    t_pose data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/twop_mul.sv -----
// bit-serial signed multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module twop_mul import twop_pkg::*; #(
    parameter int W = MUL_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output t_unit_sts             o_sts,
    output logic signed [2*W-1:0] o_prod
);

    localparam int CW = $clog2(W);

    logic signed [W-1:0] r_a;
    logic signed [W+1:0] r_h;
    logic [W-1:0]        r_l;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;

    logic signed [W+1:0] w_pp;
    logic signed [W+1:0] w_sum;
    logic                w_last;

    // partial product add, sign bit weight is subtracted
    always_comb begin
        w_pp   = r_l[0] ? (W+2)'(r_a) : '0;
        w_last = (r_cnt == CW'(W-1));
        w_sum  = w_last ? (r_h - w_pp) : (r_h + w_pp);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift-add datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_h <= '0;
            r_l <= i_b;
        end else if (r_busy) begin
            r_h <= {w_sum[W+1], w_sum[W+1:1]};
            r_l <= {w_sum[0], r_l[W-1:1]};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = {r_h[W-1:0], r_l};

endmodule

// ----- rtl/twop_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps

module twop_div import twop_pkg::*; #(
    parameter int N = DIV_N,
    parameter int D = DIV_D
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [D-1:0] i_divisor,
    output t_unit_sts    o_sts,
    output logic [N-1:0] o_quo
);

    localparam int CW = $clog2(N);

    logic [N-1:0]  r_q;
    logic [D-1:0]  r_r;
    logic [D-1:0]  r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [D:0]    w_trial;
    logic          w_ge;
    logic          w_last;

    // trial subtract of the next dividend bit
    always_comb begin
        w_trial = {r_r, r_q[N-1]};
        w_ge    = (w_trial >= {1'b0, r_d});
        w_last  = (r_cnt == CW'(N-1));
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_r <= w_ge ? D'(w_trial - {1'b0, r_d}) : w_trial[D-1:0];
            r_q <= {r_q[N-2:0], w_ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_q;

endmodule

// ----- rtl/three_wheel_odometry_pose.sv -----
// three tracking wheel arc odometry: sequencer, cordic, pose state and config port
//
//  channel  dir  handshake          payload
//  i_req    in   valid / ready      req_type, wheel positions, pose to load
//  o_pose   out  valid / ready      pose_x_out, pose_y_out, heading_out
//  apb      in   psel / penable     track_width, back_offset
//
// an update beat is paced by the one shared bit-serial multiplier, the bit-serial
// divider and the cordic; a turn within the small-turn bound skips the arc divides
// and the turn cordic pass; a set-pose beat goes from prep straight to done.
// one beat is in work at a time; the result register frees the input side while
// a finished pose waits. reset is synchronous and active low and clears the pose,
// the stored positions and the back offset, and loads the reset track width.
`timescale 1ns / 1ps

module three_wheel_odometry_pose import twop_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    twop_req_if.sink    i_req,
    twop_pose_if.source o_pose,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [4:0] C_LAST = 5'(CORDIC_STEPS - 1);
    localparam logic signed [67:0] HALF30 = 68'sd536870912;
    localparam logic signed [67:0] HALF28 = 68'sd134217728;

    // state
    t_state r_state;
    t_state n_state;
    t_mop   r_mop;
    t_dop   r_dop;
    t_cop   r_cop;

    // config
    logic [30:0]        r_track_width;
    logic signed [31:0] r_back_offset;

    // pose and stored positions
    logic signed [31:0] r_pose_x;
    logic signed [31:0] r_pose_y;
    logic [31:0]        r_heading;
    logic [31:0]        r_prev_l;
    logic [31:0]        r_prev_r;
    logic [31:0]        r_prev_b;

    // working values
    t_req               r_req;
    logic signed [31:0] r_fwd;
    logic signed [31:0] r_db;
    logic signed [31:0] r_t;
    logic [31:0]        r_turn;
    logic signed [31:0] r_side;
    logic signed [33:0] r_a;
    logic signed [33:0] r_bb;
    logic signed [33:0] r_lx;
    logic signed [33:0] r_ly;
    logic signed [33:0] r_cs;
    logic signed [33:0] r_sn;
    logic signed [67:0] r_pa;
    logic               r_dneg;

    // cordic
    logic signed [33:0] r_cx;
    logic signed [33:0] r_cy;
    logic signed [33:0] r_cz;
    logic [1:0]         r_cq;
    logic [4:0]         r_ci;

    // result register
    t_pose r_out;
    logic  r_out_valid;

    // unit hookup
    logic                     w_mul_start;
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    t_unit_sts                w_mul_sts;
    logic signed [2*MUL_W-1:0] w_prod;
    logic                     w_div_start;
    logic [DIV_N-1:0]         w_div_num;
    logic [DIV_D-1:0]         w_div_den;
    logic                     w_div_neg;
    t_unit_sts                w_div_sts;
    logic [DIV_N-1:0]         w_quo;

    // misc combinational values
    logic               w_in_ready;
    logic               w_out_free;
    logic               w_cfg_wr;
    logic signed [31:0] w_dl;
    logic signed [31:0] w_dr;
    logic signed [31:0] w_db;
    logic signed [32:0] w_sum;
    logic signed [32:0] w_sum_adj;
    logic signed [32:0] w_diff;
    logic [32:0]        w_diff_mag;
    logic signed [34:0] w_num;
    logic signed [34:0] w_num_mag;
    logic signed [31:0] w_t_mag;
    logic [61:0]        w_quo_s;
    logic [30:0]        w_t_clamp;
    logic               w_small;
    logic signed [67:0] w_tk;
    logic signed [67:0] w_tb;
    logic signed [67:0] w_lin_sub;
    logic signed [67:0] w_lin_add;
    logic signed [40:0] w_side_full;
    logic signed [40:0] w_px_full;
    logic signed [40:0] w_py_full;
    logic signed [33:0] w_cdx;
    logic signed [33:0] w_cdy;
    logic signed [33:0] w_atan;
    logic [31:0]        w_angle;

    twop_mul #(.W(MUL_W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_sts   (w_mul_sts),
        .o_prod  (w_prod)
    );

    twop_div #(.N(DIV_N), .D(DIV_D)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_sts      (w_div_sts),
        .o_quo      (w_quo)
    );

    // wheel deltas, forward motion and turn numerator
    always_comb begin
        w_dl       = r_req.left_position - $signed(r_prev_l);
        w_dr       = r_req.right_position - $signed(r_prev_r);
        w_db       = r_req.back_position - $signed(r_prev_b);
        w_sum      = 33'(w_dl) + 33'(w_dr);
        w_sum_adj  = w_sum + $signed({32'd0, w_sum[32] & w_sum[0]});
        w_diff     = 33'(w_dr) - 33'(w_dl);
        w_diff_mag = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    end

    // quotient post-processing
    always_comb begin
        w_quo_s   = r_dneg ? (62'd0 - {1'b0, w_quo}) : {1'b0, w_quo};
        w_t_clamp = (|w_quo[60:31]) ? TURN_MAG_MAX : w_quo[30:0];
        w_small   = (r_t <= TURN_EPS) && (r_t >= -TURN_EPS);
    end

    // product post-processing with round-half-up shifts
    always_comb begin
        w_tk        = w_prod + HALF30;
        w_tb        = w_prod + HALF28;
        w_lin_sub   = r_pa - w_prod + HALF30;
        w_lin_add   = r_pa + w_prod + HALF30;
        w_side_full = 41'(r_db) - 41'($signed(w_tb[67:28]));
        w_px_full   = 41'(r_pose_x) + 41'($signed(w_lin_sub[67:30]));
        w_py_full   = 41'(r_pose_y) + 41'($signed(w_lin_add[67:30]));
    end

    // cordic step terms
    always_comb begin
        w_cdx   = r_cy >>> r_ci;
        w_cdy   = r_cx >>> r_ci;
        w_atan  = $signed({2'b00, atan_bam(r_ci)});
        w_angle = (r_cop == C_TURN) ? r_turn : r_heading;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = (t_req_kind'(r_req.req_type) == REQ_SET) ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (w_div_sts.done) begin
                    n_state = (r_dop == D_A) ? S_DLAUNCH : S_MLAUNCH;
                end
            end
            S_DLAUNCH: n_state = S_DIV;
            S_MLAUNCH: n_state = S_MUL;
            S_MUL: begin
                if (w_mul_sts.done) begin
                    priority case (r_mop)
                        M_TB:    n_state = w_small ? S_MLAUNCH : S_CINIT;
                        M_AS:    n_state = S_CINIT;
                        M_YC:    n_state = S_DONE;
                        default: n_state = S_MLAUNCH;
                    endcase
                end
            end
            S_CINIT: n_state = S_CORD;
            S_CORD: begin
                if (r_ci == C_LAST) begin
                    n_state = S_CFIN;
                end
            end
            S_CFIN: begin
                n_state = (r_cop == C_TURN) ? S_DLAUNCH : S_MLAUNCH;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs and unit operands
    always_comb begin
        w_in_ready  = (r_state == S_IDLE);
        w_out_free  = !r_out_valid || o_pose.ready;
        w_mul_start = (r_state == S_MLAUNCH);
        w_div_start = ((r_state == S_PREP) && (t_req_kind'(r_req.req_type) == REQ_UPDATE))
                      || (r_state == S_DLAUNCH);

        // divider operands
        w_num     = (r_dop == D_A) ? 35'(r_sn) : (35'sd1073741824 - 35'(r_cs));
        w_num_mag = w_num[34] ? -w_num : w_num;
        w_t_mag   = r_t[31] ? -r_t : r_t;
        if (r_state == S_PREP) begin
            w_div_num = {w_diff_mag, 28'd0};
            w_div_den = (r_track_width == '0) ? 31'd1 : r_track_width;
            w_div_neg = w_diff[32];
        end else begin
            w_div_num = {w_num_mag[32:0], 28'd0};
            w_div_den = w_t_mag[30:0];
            w_div_neg = w_num[34] ^ r_t[31];
        end

        // multiplier operands
        unique case (r_mop)
            M_TK: begin
                w_mul_a = MUL_W'(r_t);
                w_mul_b = $signed({2'b00, RAD_TO_BAM_Q30});
            end
            M_TB: begin
                w_mul_a = MUL_W'(r_t);
                w_mul_b = MUL_W'(r_back_offset);
            end
            M_AF: begin
                w_mul_a = r_a;
                w_mul_b = MUL_W'(r_fwd);
            end
            M_BS: begin
                w_mul_a = r_bb;
                w_mul_b = MUL_W'(r_side);
            end
            M_BF: begin
                w_mul_a = r_bb;
                w_mul_b = MUL_W'(r_fwd);
            end
            M_AS: begin
                w_mul_a = r_a;
                w_mul_b = MUL_W'(r_side);
            end
            M_XC: begin
                w_mul_a = r_lx;
                w_mul_b = r_cs;
            end
            M_YS: begin
                w_mul_a = r_ly;
                w_mul_b = r_sn;
            end
            M_XS: begin
                w_mul_a = r_lx;
                w_mul_b = r_sn;
            end
            M_YC: begin
                w_mul_a = r_ly;
                w_mul_b = r_cs;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // pose, stored positions and sequencing tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_x  <= '0;
            r_pose_y  <= '0;
            r_heading <= '0;
            r_prev_l  <= '0;
            r_prev_r  <= '0;
            r_prev_b  <= '0;
            r_mop     <= M_TK;
            r_dop     <= D_T;
            r_cop     <= C_TURN;
        end else begin
            if (r_state == S_PREP) begin
                r_prev_l <= r_req.left_position;
                r_prev_r <= r_req.right_position;
                r_prev_b <= r_req.back_position;
                r_dop    <= D_T;
                if (t_req_kind'(r_req.req_type) == REQ_SET) begin
                    r_pose_x  <= r_req.new_x;
                    r_pose_y  <= r_req.new_y;
                    r_heading <= r_req.new_heading;
                end
            end
            if ((r_state == S_DIV) && w_div_sts.done) begin
                unique case (r_dop)
                    D_T:     r_mop <= M_TK;
                    D_A:     r_dop <= D_B;
                    D_B:     r_mop <= M_AF;
                    default: r_dop <= D_T;
                endcase
            end
            if ((r_state == S_MUL) && w_mul_sts.done) begin
                unique case (r_mop)
                    M_TK: r_mop <= M_TB;
                    M_TB: begin
                        r_mop <= M_AF;
                        r_cop <= C_TURN;
                    end
                    M_AF: r_mop <= M_BS;
                    M_BS: r_mop <= M_BF;
                    M_BF: r_mop <= M_AS;
                    M_AS: r_cop <= C_HEAD;
                    M_XC: r_mop <= M_YS;
                    M_YS: begin
                        r_mop    <= M_XS;
                        r_pose_x <= sat32(w_px_full);
                    end
                    M_XS: r_mop <= M_YC;
                    M_YC: begin
                        r_pose_y  <= sat32(w_py_full);
                        r_heading <= r_heading + r_turn;
                    end
                    default: r_mop <= M_TK;
                endcase
            end
            if (r_state == S_CFIN) begin
                if (r_cop == C_TURN) begin
                    r_dop <= D_A;
                end else begin
                    r_mop <= M_XC;
                end
            end
        end
    end

    // working datapath values
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_req.valid) begin
            r_req <= i_req.data;
        end
        if (r_state == S_PREP) begin
            r_fwd <= w_sum_adj[32:1];
            r_db  <= w_db;
        end
        if (w_div_start) begin
            r_dneg <= w_div_neg;
        end
        if ((r_state == S_DIV) && w_div_sts.done) begin
            unique case (r_dop)
                D_T:     r_t  <= r_dneg ? -$signed({1'b0, w_t_clamp}) : $signed({1'b0, w_t_clamp});
                D_A:     r_a  <= $signed(w_quo_s[33:0]);
                D_B:     r_bb <= $signed(w_quo_s[33:0]);
                default: r_a  <= r_a;
            endcase
        end
        if ((r_state == S_MUL) && w_mul_sts.done) begin
            r_pa <= w_prod;
            unique case (r_mop)
                M_TK: r_turn <= w_tk[61:30];
                M_TB: begin
                    r_side <= sat32(w_side_full);
                    // near-straight motion needs no arc correction
                    if (w_small) begin
                        r_a  <= 34'sd1073741824;
                        r_bb <= '0;
                    end
                end
                M_BS:    r_lx <= $signed(w_lin_sub[63:30]);
                M_AS:    r_ly <= $signed(w_lin_add[63:30]);
                default: ;
            endcase
        end
        // cordic: fold into one quadrant, rotate, unfold
        if (r_state == S_CINIT) begin
            r_cx <= GAIN_Q30;
            r_cy <= '0;
            r_cz <= $signed({4'd0, w_angle[29:0] + 30'h2000_0000}) - 34'sd536870912;
            r_cq <= 2'(({2'b00, w_angle[31:30]} + {3'b000, w_angle[29]}));
            r_ci <= '0;
        end
        if (r_state == S_CORD) begin
            r_ci <= r_ci + 1'b1;
            if (!r_cz[33]) begin
                r_cx <= r_cx - w_cdx;
                r_cy <= r_cy + w_cdy;
                r_cz <= r_cz - w_atan;
            end else begin
                r_cx <= r_cx + w_cdx;
                r_cy <= r_cy - w_cdy;
                r_cz <= r_cz + w_atan;
            end
        end
        if (r_state == S_CFIN) begin
            unique case (r_cq)
                2'd0: begin
                    r_cs <= r_cx;
                    r_sn <= r_cy;
                end
                2'd1: begin
                    r_cs <= -r_cy;
                    r_sn <= r_cx;
                end
                2'd2: begin
                    r_cs <= -r_cx;
                    r_sn <= -r_cy;
                end
                default: begin
                    r_cs <= r_cy;
                    r_sn <= -r_cx;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            priority if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_pose.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out.pose_x_out  <= r_pose_x;
            r_out.pose_y_out  <= r_pose_y;
            r_out.heading_out <= r_heading;
        end
    end

    // config registers
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_width <= TRACK_WIDTH_RST;
            r_back_offset <= '0;
        end else if (w_cfg_wr) begin
            unique case (t_reg'(paddr[2]))
                REG_TRACK_WIDTH: r_track_width <= pwdata[30:0];
                REG_BACK_OFFSET: r_back_offset <= pwdata;
                default:         r_back_offset <= r_back_offset;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[2]))
            REG_TRACK_WIDTH: prdata = {1'b0, r_track_width};
            REG_BACK_OFFSET: prdata = r_back_offset;
            default:         prdata = '0;
        endcase
    end

    // ports
    assign pready       = 1'b1;
    assign i_req.ready  = w_in_ready;
    assign o_pose.valid = r_out_valid;
    assign o_pose.data  = r_out;

    // checks
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_mul_sts.busy, w_div_sts.busy, r_state == S_CORD}))
        else $error("serial units overlap");

    a_idle_units_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_mul_sts.busy && !w_div_sts.busy))
        else $error("unit busy while idle");

    a_done_posts_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && w_out_free) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished beat not posted");

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_PREP))
        else $error("accepted beat not started");

endmodule
